// ===== rtl/core/tlnef_pkg.sv =====
// Package for the text line number and escape filter: item types, config, constants.
`default_nettype none
package tlnef_pkg;

  // Parameter defaults and limits
  localparam int CountDigitsDef = 7;
  localparam int PadWidthDef    = 6;
  localparam int QueueDepth     = 2;

  // Character codes
  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChNl     = 8'd10;
  localparam logic [7:0] ChSpace  = 8'd32;
  localparam logic [7:0] ChDel    = 8'd127;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCaret  = 8'h5e;
  localparam logic [7:0] ChI      = 8'h49;
  localparam logic [7:0] ChQuest  = 8'h3f;
  localparam logic [7:0] CtrlOffset = 8'd64;
  localparam logic [3:0] DigitHigh  = 4'h3;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } cfg_reg_e;
  localparam int CfgDataW = 1;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Classified item handed from front to back (count travels beside it)
  typedef struct packed {
    logic       num_en;
    logic [7:0] tail_a;
    logic [7:0] tail_b;
    logic       tail_two;
  } cmd_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/text_line_number_and_escape_filter.sv =====
// Top level of the text line number and escape filter.
//
// Input channel: one text byte per item with a file start flag, valid/stall.
// Output channel: one filtered byte per item, last_of_run marks the final
// byte made by an input byte; valid/stall. Configuration: write enable,
// register index and one data bit, taken at any edge the enable is high.
// The front end classifies each byte in its accept cycle and pushes it into a
// two-entry queue; the back end turns the queue head into bytes, one per cycle
// while the receiver does not stall, through a registered output. The first byte
// of an item passes the queue and then the output register. An item makes 1 to
// max(PAD_WIDTH, COUNT_DIGITS) + 3 bytes and holds the back end until its last
// byte is out; with one byte per item the block takes one input byte every cycle.
// A squeezed blank line makes no bytes and never enters the queue. When the
// receiver stalls, the output item holds and the queue fills, then the input stalls.
// Reset clears the line state, the count, the queue and the config flags.
`default_nettype none
module text_line_number_and_escape_filter #(
  parameter int COUNT_DIGITS = tlnef_pkg::CountDigitsDef,
  parameter int PAD_WIDTH    = tlnef_pkg::PadWidthDef
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire [tlnef_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire [tlnef_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire tlnef_pkg::in_item_t              in_item_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output tlnef_pkg::out_item_t                  out_item_o
);
  import tlnef_pkg::*;

  localparam int CntW = 4 * COUNT_DIGITS;
  localparam int QW   = $bits(cmd_ctrl_t) + CntW;

  cfg_t            cfg_q;
  logic            push_valid, full, empty, pop;
  cmd_ctrl_t       push_ctrl, head_ctrl;
  logic [CntW-1:0] push_cnt, head_cnt;
  logic [QW-1:0]   rdata;

  // Configuration flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_wdata_i[0];
        REG_NUMBER_ALL:       cfg_q.number_all       <= cfg_wdata_i[0];
        REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_wdata_i[0];
        REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_wdata_i[0];
        REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_wdata_i[0];
        REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tlnef_front #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_valid_o(push_valid),
    .push_stall_i(full),
    .push_ctrl_o (push_ctrl),
    .push_cnt_o  (push_cnt)
  );

  tlnef_fifo #(
    .Width(QW),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_valid),
    .full_o (full),
    .wdata_i({push_ctrl, push_cnt}),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(rdata)
  );

  assign head_ctrl = rdata[QW-1:CntW];
  assign head_cnt  = rdata[CntW-1:0];

  tlnef_back #(
    .COUNT_DIGITS(COUNT_DIGITS),
    .PAD_WIDTH   (PAD_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .head_ctrl_i(head_ctrl),
    .head_cnt_i (head_cnt),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tlnef_front.sv =====
// Front end: accepts bytes, tracks line state and count, classifies each item.
`default_nettype none
module tlnef_front #(
  parameter int COUNT_DIGITS = tlnef_pkg::CountDigitsDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire tlnef_pkg::cfg_t          cfg_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire tlnef_pkg::in_item_t      in_item_i,
  output logic                          push_valid_o,
  input  wire                           push_stall_i,
  output tlnef_pkg::cmd_ctrl_t          push_ctrl_o,
  output logic [4*COUNT_DIGITS-1:0]     push_cnt_o
);
  import tlnef_pkg::*;

  localparam int CntW = 4 * COUNT_DIGITS;

  logic            at_start_q, at_start_d;
  logic            prev_blank_q, prev_blank_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            accept;
  logic            line_start, blank, squeeze, num;
  logic [CntW-1:0] cnt_base, cnt_inc;
  logic            all_nine, carry;
  logic [7:0]      c;

  assign c          = in_item_i.in_byte;
  assign in_stall_o = push_stall_i;
  assign accept     = in_valid_i && !push_stall_i;

  // Line start and blank classification
  assign line_start = at_start_q || in_item_i.file_start;
  assign cnt_base   = in_item_i.file_start ? '0 : cnt_q;
  assign blank      = (c == ChNl);
  assign squeeze    = line_start && cfg_i.squeeze_blank && blank && prev_blank_q;
  assign num        = line_start && !squeeze &&
                      (cfg_i.number_nonblank ? !blank : cfg_i.number_all);

  // Saturating BCD increment, carry ripples digit by digit
  always_comb begin
    all_nine = 1'b1;
    carry    = 1'b1;
    cnt_inc  = cnt_base;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (cnt_base[4*i +: 4] != 4'd9) all_nine = 1'b0;
    end
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (carry) begin
        if (cnt_base[4*i +: 4] == 4'd9) begin
          cnt_inc[4*i +: 4] = 4'd0;
        end else begin
          cnt_inc[4*i +: 4] = cnt_base[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nine) cnt_inc = cnt_base;
  end

  // Bytes that stand for the raw byte itself
  always_comb begin
    push_ctrl_o.num_en   = num;
    push_ctrl_o.tail_a   = c;
    push_ctrl_o.tail_b   = c;
    push_ctrl_o.tail_two = 1'b0;
    if (c == ChTab && cfg_i.show_tabs) begin
      push_ctrl_o.tail_a   = ChCaret;
      push_ctrl_o.tail_b   = ChI;
      push_ctrl_o.tail_two = 1'b1;
    end else if (c == ChNl) begin
      if (cfg_i.show_ends) begin
        push_ctrl_o.tail_a   = ChDollar;
        push_ctrl_o.tail_two = 1'b1;
      end
      push_ctrl_o.tail_b = ChNl;
    end else if (cfg_i.show_nonprinting && c < ChSpace && c != ChTab) begin
      push_ctrl_o.tail_a   = ChCaret;
      push_ctrl_o.tail_b   = c + CtrlOffset;
      push_ctrl_o.tail_two = 1'b1;
    end else if (cfg_i.show_nonprinting && c == ChDel) begin
      push_ctrl_o.tail_a   = ChCaret;
      push_ctrl_o.tail_b   = ChQuest;
      push_ctrl_o.tail_two = 1'b1;
    end
  end

  assign cnt_d        = num ? cnt_inc : cnt_base;
  assign push_cnt_o   = cnt_d;
  assign push_valid_o = in_valid_i && !squeeze;

  // Next line state
  always_comb begin
    at_start_d   = at_start_q;
    prev_blank_d = prev_blank_q;
    if (accept) begin
      at_start_d = squeeze ? 1'b1 : blank;
      if (line_start && !squeeze) prev_blank_d = blank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q   <= 1'b1;
      prev_blank_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      at_start_q   <= at_start_d;
      prev_blank_q <= prev_blank_d;
      if (accept) cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tlnef_fifo.sv =====
// Small register queue between front and back.
`default_nettype none
module tlnef_fifo #(
  parameter int Width = 8,
  parameter int Depth = tlnef_pkg::QueueDepth
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  output logic             full_o,
  input  wire [Width-1:0]  wdata_i,
  input  wire              pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);
  import tlnef_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tlnef_back.sv =====
// Back end: expands each queued item into padded number, tab and escaped bytes.
`default_nettype none
module tlnef_back #(
  parameter int COUNT_DIGITS = tlnef_pkg::CountDigitsDef,
  parameter int PAD_WIDTH    = tlnef_pkg::PadWidthDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          empty_i,
  output logic                         pop_o,
  input  wire tlnef_pkg::cmd_ctrl_t    head_ctrl_i,
  input  wire [4*COUNT_DIGITS-1:0]     head_cnt_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output tlnef_pkg::out_item_t         out_item_o
);
  import tlnef_pkg::*;

  localparam int NumMax = (PAD_WIDTH > COUNT_DIGITS) ? PAD_WIDTH : COUNT_DIGITS;
  localparam int MaxLen = NumMax + 3;
  localparam int IdxW   = $clog2(MaxLen + 1);
  localparam logic [IdxW-1:0] PadLen = IdxW'(PAD_WIDTH);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q;
  out_item_t       out_q;

  logic [IdxW-1:0] sig, num_len, base, di;
  logic [3:0]      digit;
  logic [7:0]      ch;
  logic            last, emit;

  // Significant digits of the count, at least one
  always_comb begin
    sig = IdxW'(1);
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (head_cnt_i[4*i +: 4] != 4'd0) sig = IdxW'(i + 1);
    end
  end

  assign num_len = (sig > PadLen) ? sig : PadLen;
  assign base    = head_ctrl_i.num_en ? num_len + IdxW'(1) : '0;
  assign di      = num_len - IdxW'(1) - idx_q;

  // Digit at the current print position
  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (di == IdxW'(i)) digit = head_cnt_i[4*i +: 4];
    end
  end

  // Byte at the current position of the run
  always_comb begin
    if (idx_q == base) begin
      ch = head_ctrl_i.tail_a;
    end else if (idx_q > base) begin
      ch = head_ctrl_i.tail_b;
    end else if (idx_q == base - IdxW'(1)) begin
      ch = ChTab;
    end else if (di < sig) begin
      ch = {DigitHigh, digit};
    end else begin
      ch = ChSpace;
    end
  end

  assign last  = (idx_q == base + IdxW'(head_ctrl_i.tail_two));
  assign emit  = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && last;
  assign idx_d = emit ? (last ? '0 : idx_q + IdxW'(1)) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= ch;
      out_q.last_of_run <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire
